@@ rtl/pal_pkg.sv @@
// ----------------------------------------------------------------------------
// pal_pkg: shared types and codes for the positional array list
// Request kinds, status codes, default sizes and the structs that pass
// between the top level and the sequencer.
// ----------------------------------------------------------------------------
package pal_pkg;

    // fixed field widths of the request and result beats
    localparam int KIND_W  = 2;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int CNT_W   = 7;
    localparam int MAX_DW  = 64;
    localparam int FILL_XW = 8;

    // default sizes
    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_POP    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd3;

    // result status codes
    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    // captured request
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [POS_W-1:0]  pos;
        logic [MAX_DW-1:0] value;
    } t_req;

    // sequencer status and result beat
    typedef struct packed {
        logic               busy;
        logic               done;
        logic [STAT_W-1:0]  status;
        logic [VAL_W-1:0]   value;
        logic [FILL_XW-1:0] fill;
    } t_rsp;

endpackage

@@ rtl/positional_array_list.sv @@
// ----------------------------------------------------------------------------
// positional_array_list: fixed-capacity ordered list with 1-based positions
// Get, insert, pop and clear requests; one result beat per request.
// ----------------------------------------------------------------------------
// error, clear and append results come from the check state, get reads the
//   entry ram first, insert and pop at p shift the entries from p to the end,
//   one entry move per cycle through the entry ram port pair
// busy after accept until the result strobe; the next request may be accepted
//   in the strobe cycle; the receiver cannot stall results
// reset (synchronous, active low) empties the list; entry ram is not cleared
module positional_array_list #(
    parameter int CAPACITY   = pal_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = pal_pkg::DEF_DATA_WIDTH
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [pal_pkg::KIND_W-1:0] i_kind,
    input  logic [pal_pkg::POS_W-1:0]  i_position,
    input  logic [pal_pkg::VAL_W-1:0]  i_value_in,
    output logic                       o_done,
    output logic [pal_pkg::STAT_W-1:0] o_status,
    output logic [pal_pkg::VAL_W-1:0]  o_value_out,
    output logic [pal_pkg::CNT_W-1:0]  o_count
);
    import pal_pkg::*;

    t_req r_req;
    t_rsp rsp;
    logic accept;

    assign accept = start && !rsp.busy;

    // request capture
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.kind  <= i_kind;
            r_req.pos   <= i_position;
            r_req.value <= MAX_DW'(i_value_in);
        end
    end

    // sequencer with entry store
    pal_seq #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (r_req),
        .o_rsp    (rsp)
    );

    // result ports
    assign busy        = rsp.busy;
    assign o_done      = rsp.done;
    assign o_status    = rsp.status;
    assign o_value_out = rsp.value;
    assign o_count     = rsp.fill[CNT_W-1:0];

    // checks
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> rsp.busy)
        else $error("busy not raised after accepted request");

    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |=> !rsp.done)
        else $error("result strobe longer than one beat");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.done |-> !rsp.busy)
        else $error("result strobe while sequencer still busy");

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp.fill <= FILL_XW'(CAPACITY))
        else $error("fill count beyond capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rsp.done && rsp.status == ST_FULL) |-> (rsp.fill == FILL_XW'(CAPACITY)))
        else $error("full status reported below capacity");

endmodule

@@ rtl/pal_ram.sv @@
// ----------------------------------------------------------------------------
// pal_ram: generic single-clock ram
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pal_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pal_seq.sv @@
// ----------------------------------------------------------------------------
// pal_seq: list sequencer
// Checks get, insert and pop requests against the fill count and walks
// the shift moves through the single ram port pair, one entry moved per
// cycle, with one shared address stepper.
// ----------------------------------------------------------------------------
module pal_seq #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  pal_pkg::t_req i_req,
    output pal_pkg::t_rsp o_rsp
);
    import pal_pkg::*;

    localparam int AW = $clog2(CAPACITY);
    localparam int FW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CHK  = 3'd1;
    localparam logic [2:0] S_GETD = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_INSV = 3'd4;
    localparam logic [2:0] S_POPV = 3'd5;
    localparam logic [2:0] S_POP  = 3'd6;

    logic [2:0]            r_state, n_state;
    logic [FW-1:0]         r_fill, n_fill;
    logic [AW-1:0]         r_rad, n_rad;
    logic [AW-1:0]         r_wad, n_wad;
    logic [DATA_WIDTH-1:0] r_hold, n_hold;
    logic                  r_done, n_done;
    logic [STAT_W-1:0]     r_status, n_status;
    logic [VAL_W-1:0]      r_value, n_value;

    logic                  ram_we;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [POS_W:0]        pos_x;
    logic [POS_W:0]        fill_x;
    logic                  pos_nz;
    logic                  in_list;
    logic                  ins_ok;
    logic                  is_full;
    logic                  is_append;
    logic [AW-1:0]         pos_a;
    logic [AW-1:0]         last_a;
    logic [AW-1:0]         rad_step;
    logic [DATA_WIDTH-1:0] req_data;
    logic [MAX_DW-1:0]     rd_ext;
    logic [MAX_DW-1:0]     hold_ext;

    // entry store
    pal_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // range checks against the fill count
    assign pos_x     = (POS_W+1)'(i_req.pos);
    assign fill_x    = (POS_W+1)'(r_fill);
    assign pos_nz    = (i_req.pos != '0);
    assign in_list   = pos_nz && (pos_x <= fill_x);
    assign ins_ok    = pos_nz && (pos_x <= fill_x + (POS_W+1)'(1));
    assign is_full   = (r_fill == FW'(CAPACITY));
    assign is_append = (pos_x == fill_x + (POS_W+1)'(1));
    assign pos_a     = AW'(i_req.pos - POS_W'(1));
    assign last_a    = AW'(r_fill - FW'(1));
    assign req_data  = i_req.value[DATA_WIDTH-1:0];

    // shared address stepper: down while inserting, up while popping
    assign rad_step = r_rad + ((r_state == S_INS) ? {AW{1'b1}} : AW'(1));

    // read data widened to the result field
    assign rd_ext   = MAX_DW'(ram_rdata);
    assign hold_ext = MAX_DW'(r_hold);

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_rad     = r_rad;
        n_wad     = r_wad;
        n_hold    = r_hold;
        n_done    = 1'b0;
        n_status  = r_status;
        n_value   = r_value;
        ram_we    = 1'b0;
        ram_waddr = r_wad;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = rad_step;

        unique case (r_state)
            S_IDLE: begin
                if (i_accept) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                unique case (i_req.kind)
                    KIND_GET: begin
                        if (in_list) begin
                            ram_re    = 1'b1;
                            ram_raddr = pos_a;
                            n_state   = S_GETD;
                        end else begin
                            n_done   = 1'b1;
                            n_status = ST_BADPOS;
                            n_value  = '0;
                            n_state  = S_IDLE;
                        end
                    end
                    KIND_INSERT: begin
                        if (is_full) begin
                            n_done   = 1'b1;
                            n_status = ST_FULL;
                            n_value  = '0;
                            n_state  = S_IDLE;
                        end else if (!ins_ok) begin
                            n_done   = 1'b1;
                            n_status = ST_BADPOS;
                            n_value  = '0;
                            n_state  = S_IDLE;
                        end else if (is_append) begin
                            ram_we    = 1'b1;
                            ram_waddr = pos_a;
                            ram_wdata = req_data;
                            n_fill    = r_fill + FW'(1);
                            n_done    = 1'b1;
                            n_status  = ST_OK;
                            n_value   = '0;
                            n_state   = S_IDLE;
                        end else begin
                            ram_re    = 1'b1;
                            ram_raddr = last_a;
                            n_rad     = last_a;
                            n_wad     = AW'(r_fill);
                            n_state   = S_INS;
                        end
                    end
                    KIND_POP: begin
                        if (in_list) begin
                            ram_re    = 1'b1;
                            ram_raddr = pos_a;
                            n_rad     = pos_a;
                            n_state   = S_POPV;
                        end else begin
                            n_done   = 1'b1;
                            n_status = ST_BADPOS;
                            n_value  = '0;
                            n_state  = S_IDLE;
                        end
                    end
                    default: begin
                        n_fill   = '0;
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_value  = '0;
                        n_state  = S_IDLE;
                    end
                endcase
            end
            S_GETD: begin
                n_done   = 1'b1;
                n_status = ST_OK;
                n_value  = rd_ext[VAL_W-1:0];
                n_state  = S_IDLE;
            end
            S_INS: begin
                // move one entry up, fetch the next lower one
                ram_we = 1'b1;
                if (r_rad == pos_a) begin
                    n_state = S_INSV;
                end else begin
                    ram_re = 1'b1;
                    n_rad  = rad_step;
                    n_wad  = r_rad;
                end
            end
            S_INSV: begin
                ram_we    = 1'b1;
                ram_waddr = pos_a;
                ram_wdata = req_data;
                n_fill    = r_fill + FW'(1);
                n_done    = 1'b1;
                n_status  = ST_OK;
                n_value   = '0;
                n_state   = S_IDLE;
            end
            S_POPV: begin
                n_hold = ram_rdata;
                if (pos_x == fill_x) begin
                    n_fill   = r_fill - FW'(1);
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_value  = rd_ext[VAL_W-1:0];
                    n_state  = S_IDLE;
                end else begin
                    ram_re  = 1'b1;
                    n_rad   = rad_step;
                    n_wad   = r_rad;
                    n_state = S_POP;
                end
            end
            S_POP: begin
                // move one entry down, fetch the next higher one
                ram_we = 1'b1;
                if (r_rad == last_a) begin
                    n_fill   = r_fill - FW'(1);
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_value  = hold_ext[VAL_W-1:0];
                    n_state  = S_IDLE;
                end else begin
                    ram_re = 1'b1;
                    n_rad  = rad_step;
                    n_wad  = r_rad;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_fill  <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fill  <= n_fill;
            r_done  <= n_done;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rad    <= n_rad;
        r_wad    <= n_wad;
        r_hold   <= n_hold;
        r_status <= n_status;
        r_value  <= n_value;
    end

    assign o_rsp.busy   = (r_state != S_IDLE);
    assign o_rsp.done   = r_done;
    assign o_rsp.status = r_status;
    assign o_rsp.value  = r_value;
    assign o_rsp.fill   = FILL_XW'(r_fill);

endmodule

@@ bench/positional_array_list_tb.sv @@
// ----------------------------------------------------------------------------
// positional_array_list_tb: self-checking bench for the positional array list
// Sends get, insert, pop and clear requests with random gaps. A tracker
// mirrors the list contents and fill, predicts each result beat and checks
// the beats that come out field by field and in order.
// ----------------------------------------------------------------------------
module positional_array_list_tb;
    import pal_pkg::*;

    localparam int LIST_CAP     = DEF_CAPACITY;
    localparam int RANDOM_BEATS = 1600;

    // one predicted result beat
    typedef struct {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value;
        logic [CNT_W-1:0]  count;
    } t_list_result;

    // mirrors the list and holds the result beats still to come
    class pal_list_tracker;
        logic [VAL_W-1:0] words [LIST_CAP];
        int               fill;
        t_list_result     pending [$];
        int               errors;

        function new();
            fill   = 0;
            errors = 0;
        endfunction

        task report_mismatch(input string msg);
            errors++;
            if (errors <= 40) $display("mismatch at %0t: %s", $time, msg);
        endtask

        // apply one accepted request and queue the beat it must produce
        function void note_request(input logic [KIND_W-1:0] kind,
                                   input logic [POS_W-1:0] pos,
                                   input logic [VAL_W-1:0] value);
            t_list_result r;
            int           p;
            int           k;
            p        = pos;
            r.status = ST_OK;
            r.value  = '0;
            case (kind)
                KIND_GET: begin
                    if (p < 1 || p > fill) r.status = ST_BADPOS;
                    else r.value = words[p-1];
                end
                KIND_INSERT: begin
                    if (fill >= LIST_CAP) begin
                        r.status = ST_FULL;
                    end else if (p < 1 || p > fill + 1) begin
                        r.status = ST_BADPOS;
                    end else begin
                        for (k = fill; k >= p; k--) words[k] = words[k-1];
                        words[p-1] = value;
                        fill++;
                    end
                end
                KIND_POP: begin
                    if (p < 1 || p > fill) begin
                        r.status = ST_BADPOS;
                    end else begin
                        r.value = words[p-1];
                        for (k = p; k < fill; k++) words[k-1] = words[k];
                        fill--;
                    end
                end
                KIND_CLEAR: begin
                    fill = 0;
                end
                default: ;
            endcase
            r.count = fill[CNT_W-1:0];
            pending.push_back(r);
        endfunction

        // compare one result beat with the oldest prediction
        task check_result(input logic [STAT_W-1:0] status,
                          input logic [VAL_W-1:0] value,
                          input logic [CNT_W-1:0] count);
            t_list_result exp_r;
            if (pending.size() == 0) begin
                report_mismatch("result beat with no request outstanding");
            end else begin
                exp_r = pending.pop_front();
                if (status !== exp_r.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              status, exp_r.status));
                if (value !== exp_r.value)
                    report_mismatch($sformatf("value got %08h want %08h",
                                              value, exp_r.value));
                if (count !== exp_r.count)
                    report_mismatch($sformatf("count got %0d want %0d",
                                              count, exp_r.count));
            end
        endtask
    endclass

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               start      = 1'b0;
    logic [KIND_W-1:0]  i_kind     = KIND_GET;
    logic [POS_W-1:0]   i_position = '0;
    logic [VAL_W-1:0]   i_value_in = '0;
    logic               busy;
    logic               o_done;
    logic [STAT_W-1:0]  o_status;
    logic [VAL_W-1:0]   o_value_out;
    logic [CNT_W-1:0]   o_count;

    pal_list_tracker tracker = new();
    int              random_sent;

    positional_array_list u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_kind      (i_kind),
        .i_position  (i_position),
        .i_value_in  (i_value_in),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_value_out (o_value_out),
        .o_count     (o_count)
    );

    // clock, period 2
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result beats are taken at the edge that ends their strobe cycle
    always @(posedge i_clk) begin
        if (i_rst_n && o_done === 1'b1) tracker.check_result(o_status, o_value_out, o_count);
    end

    // hold one request until the block takes it
    task automatic send_req(input logic [KIND_W-1:0] kind, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] value);
        start      <= 1'b1;
        i_kind     <= kind;
        i_position <= pos;
        i_value_in <= value;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        tracker.note_request(kind, pos, value);
    endtask

    // mostly short gaps, a few long ones; fields carry noise while idle
    task automatic idle_gap(input bit burst);
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (burst || r < 55) n = 0;
        else if (r < 85) n = $urandom_range(1, 3);
        else if (r < 97) n = $urandom_range(4, 12);
        else n = $urandom_range(20, 60);
        if (n > 0) begin
            start      <= 1'b0;
            i_kind     <= KIND_W'($urandom());
            i_position <= POS_W'($urandom());
            i_value_in <= VAL_W'($urandom());
            repeat (n) @(posedge i_clk);
        end
    endtask

    // stop sending until every predicted beat has come back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending.size() != 0) @(posedge i_clk);
    endtask

    // mostly legal positions, with zero, just past the end and anything
    function automatic logic [POS_W-1:0] pick_position(input logic [KIND_W-1:0] kind);
        int limit;
        int r;
        limit = (kind == KIND_INSERT) ? tracker.fill + 1 : tracker.fill;
        r     = $urandom_range(0, 99);
        if (r < 80 && limit >= 1) return POS_W'($urandom_range(1, limit));
        if (r < 86) return '0;
        if (r < 92 && limit < 255) return POS_W'(limit + 1);
        return POS_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return '1;
        return VAL_W'($urandom());
    endfunction

    // one random request drawn from the given kind weights
    task automatic random_request(input int w_ins, input int w_pop, input int w_get,
                                  input int w_clr, input bit burst);
        logic [KIND_W-1:0] kind;
        int                r;
        r = $urandom_range(0, w_ins + w_pop + w_get + w_clr - 1);
        if (r < w_ins) kind = KIND_INSERT;
        else if (r < w_ins + w_pop) kind = KIND_POP;
        else if (r < w_ins + w_pop + w_get) kind = KIND_GET;
        else kind = KIND_CLEAR;
        send_req(kind, pick_position(kind), pick_value());
        random_sent++;
        idle_gap(burst);
    endtask

    // directed corner cases on a short list
    task automatic directed_requests();
        send_req(KIND_GET, 8'd1, '0);            idle_gap(0);
        send_req(KIND_POP, 8'd1, '0);            idle_gap(0);
        send_req(KIND_INSERT, 8'd0, 32'h1111_1111); idle_gap(0);
        send_req(KIND_INSERT, 8'd2, 32'h2222_2222); idle_gap(0);
        send_req(KIND_INSERT, 8'd1, 32'hFFFF_FFFF); idle_gap(0);
        send_req(KIND_INSERT, 8'd1, 32'h0000_0000); idle_gap(0);
        send_req(KIND_INSERT, 8'd3, 32'hA5A5_A5A5); idle_gap(0);
        send_req(KIND_INSERT, 8'd2, 32'h5A5A_5A5A); idle_gap(0);
        send_req(KIND_GET, 8'd0, '0);            idle_gap(0);
        for (int p = 1; p <= 5; p++) begin
            send_req(KIND_GET, POS_W'(p), '0);
            idle_gap(0);
        end
        send_req(KIND_GET, 8'd255, '1);          idle_gap(0);
        send_req(KIND_INSERT, 8'd255, '1);       idle_gap(0);
        send_req(KIND_POP, 8'd255, '0);          idle_gap(0);
        // middle, last, then front
        send_req(KIND_POP, 8'd2, '0);            idle_gap(0);
        send_req(KIND_POP, 8'd3, '0);            idle_gap(0);
        send_req(KIND_POP, 8'd1, '0);            idle_gap(0);
        send_req(KIND_CLEAR, 8'd0, '0);          idle_gap(0);
        send_req(KIND_GET, 8'd1, '0);            idle_gap(0);
        send_req(KIND_INSERT, 8'd1, 32'h1234_5678); idle_gap(0);
        send_req(KIND_GET, 8'd1, '0);            idle_gap(0);
        send_req(KIND_POP, 8'd1, '0);
    endtask

    // stimulus
    initial begin
        int  round;
        int  n;
        int  profile;
        bit  burst;
        random_sent = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_requests();
        drain_results();

        // fill to capacity, then push inserts against the full list
        while (tracker.fill < LIST_CAP) random_request(85, 5, 10, 0, 0);
        repeat (8) random_request(1, 0, 0, 0, 0);
        drain_results();

        // empty it again mostly through pops
        n = 0;
        while (tracker.fill > 0 && n < 300) begin
            random_request(5, 80, 15, 0, 0);
            n++;
        end

        round = 0;
        while (random_sent < RANDOM_BEATS) begin
            profile = $urandom_range(0, 3);
            burst   = ($urandom_range(0, 3) == 0);
            n       = $urandom_range(20, 120);
            repeat (n) begin
                case (profile)
                    0: random_request(70, 10, 18, 2, burst);
                    1: random_request(10, 65, 23, 2, burst);
                    2: random_request(35, 30, 33, 2, burst);
                    default: random_request(45, 20, 20, 15, burst);
                endcase
            end
            if ($urandom_range(0, 3) == 0) drain_results();
            round++;
        end

        drain_results();
        repeat (LIST_CAP + 8) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("positional_array_list_tb passed");
        end else begin
            $display("positional_array_list_tb failed");
        end
        $finish;
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("positional_array_list_tb failed");
        $finish;
    end

endmodule

@@ positional_array_list.f @@
rtl/pal_pkg.sv
rtl/pal_ram.sv
rtl/pal_seq.sv
rtl/positional_array_list.sv
bench/positional_array_list_tb.sv
